/* rtl/pafb_pkg.sv */
// package for the partition allocator: status codes, opcodes and queue types
// no dependencies
package pafb_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_NOTASK  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_BADSIZE = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int unsigned CfgFitMode  = 0;
  localparam int unsigned CfgSplitThr = 1;

  // classified request handed from front to back
  typedef struct packed {
    logic        op;
    logic        bad_size;
    logic [15:0] task_id;
    logic [10:0] size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  start_addr;
    logic [10:0] granted_size;
  } rsp_t;

endpackage

/* rtl/pafb_front.sv */
// front end: accepts request words, classifies them and queues them
// depends on pafb_pkg
module pafb_front
  import pafb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [27:0] s_data_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output req_t        q_req_o
);

  // two-entry queue
  req_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       req;

  always_comb begin
    req.op       = s_data_i[0];
    req.task_id  = s_data_i[16:1];
    req.size     = s_data_i[27:17];
    req.bad_size = (s_data_i[0] == OP_ALLOC) && (s_data_i[27:17] == 11'd0);
  end

  assign s_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = mem_q[rp_q];

  logic push, pop;
  assign push = s_valid_i && s_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* rtl/pafb_back.sv */
// back end: partition table and the sequencer that scans, splits and merges it
// depends on pafb_pkg
module pafb_back
  import pafb_pkg::*;
#(
  parameter int unsigned MemoryUnits   = 1024,
  parameter int unsigned MaxPartitions = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fit_mode_i,
  input  logic [10:0] split_thr_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  req_t        q_req_i,
  output logic        r_valid_o,
  input  logic        r_ready_i,
  output rsp_t        r_rsp_o
);

  localparam int unsigned AW = $clog2(MemoryUnits);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned IW = $clog2(MaxPartitions);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = (LW > 11) ? LW : 11;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_PICK  = 9'b000001000,
    S_SHIFT = 9'b000010000,
    S_SPLIT = 9'b000100000,
    S_GRANT = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [15:0]   owner;
    logic          busy;
    logic [LW-1:0] len;
    logic [AW-1:0] start;
  } entry_t;

  // partition table: one registered read and one write per cycle
  entry_t        tbl_mem [MaxPartitions];
  entry_t        rdata_q;
  logic          rvld_q;
  logic [IW-1:0] ri_q;
  logic [CW-1:0] count_q;

  state_e        st_q;
  req_t          req_q;
  logic [CW-1:0] i_q, w_q;
  logic          pick_v_q, found_q;
  logic [IW-1:0] pick_q;
  entry_t        pick_e_q;
  entry_t        acc_q;
  rsp_t          res_q;
  rsp_t          rsp_q;
  logic          rv_q;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;
  logic          issue, hit, scan_fit, merge;
  entry_t        free_e;
  logic [SW-1:0] left;

  function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [9:0] addr,
                                  input logic [10:0] len);
    rsp_t r;
    r.status       = st;
    r.start_addr   = addr;
    r.granted_size = len;
    return r;
  endfunction

  assign q_ready_o = (st_q == S_IDLE);
  assign r_valid_o = rv_q;
  assign r_rsp_o   = rsp_q;

  assign issue    = (i_q != count_q);
  assign hit      = rdata_q.busy && (rdata_q.owner == req_q.task_id);
  assign scan_fit = !rdata_q.busy && (SW'(rdata_q.len) >= SW'(req_q.size));
  assign merge    = (w_q != '0) && !free_e.busy && !acc_q.busy;
  assign left     = SW'(pick_e_q.len) - SW'(req_q.size);
  assign mem_raddr = i_q[IW-1:0];

  // entry as seen by a free: released when it belongs to the task
  always_comb begin
    free_e = rdata_q;
    if (hit) begin
      free_e.busy  = 1'b0;
      free_e.owner = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (st_q)
      S_INIT: begin
        mem_we        = 1'b1;
        mem_wdata.len = LW'(MemoryUnits);
      end
      S_SHIFT: begin
        if (rvld_q) begin
          mem_we    = 1'b1;
          mem_waddr = ri_q + 1'b1;
          mem_wdata = rdata_q;
        end
      end
      S_SPLIT: begin
        mem_we          = 1'b1;
        mem_waddr       = pick_q + 1'b1;
        mem_wdata.start = pick_e_q.start + AW'(req_q.size);
        mem_wdata.len   = LW'(left);
      end
      S_GRANT: begin
        mem_we          = 1'b1;
        mem_waddr       = pick_q;
        mem_wdata.owner = req_q.task_id;
        mem_wdata.busy  = 1'b1;
        mem_wdata.len   = pick_e_q.len;
        mem_wdata.start = pick_e_q.start;
      end
      S_FREE: begin
        // each kept entry goes out to slot w_q - 1 once no further entry merges into it
        if (rvld_q) begin
          if (!merge && w_q != '0) begin
            mem_we    = 1'b1;
            mem_waddr = IW'(w_q - 1'b1);
            mem_wdata = acc_q;
          end
        end else if (!issue) begin
          mem_we    = 1'b1;
          mem_waddr = IW'(w_q - 1'b1);
          mem_wdata = acc_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
    rdata_q <= tbl_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_INIT;
      count_q  <= CW'(1);
      rvld_q   <= 1'b0;
      ri_q     <= '0;
      req_q    <= '0;
      i_q      <= '0;
      w_q      <= '0;
      pick_v_q <= 1'b0;
      found_q  <= 1'b0;
      pick_q   <= '0;
      pick_e_q <= '0;
      acc_q    <= '0;
      res_q    <= '0;
    end else begin
      unique case (st_q)
        S_INIT: st_q <= S_IDLE;
        S_IDLE: begin
          rvld_q <= 1'b0;
          if (q_valid_i) begin
            req_q    <= q_req_i;
            i_q      <= '0;
            w_q      <= '0;
            pick_v_q <= 1'b0;
            found_q  <= 1'b0;
            if (q_req_i.op == OP_FREE) st_q <= S_FREE;
            else if (q_req_i.bad_size) begin
              res_q <= mk_rsp(ST_BADSIZE, '0, '0);
              st_q  <= S_RESP;
            end else st_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            rvld_q <= 1'b1;
            ri_q   <= i_q[IW-1:0];
            i_q    <= i_q + 1'b1;
          end else rvld_q <= 1'b0;
          if (rvld_q && scan_fit &&
              (!pick_v_q || (fit_mode_i && rdata_q.len < pick_e_q.len))) begin
            pick_v_q <= 1'b1;
            pick_q   <= ri_q;
            pick_e_q <= rdata_q;
          end
          // first fit stops at the first hit
          if ((rvld_q && scan_fit && !fit_mode_i) || (!issue && !rvld_q)) st_q <= S_PICK;
        end
        S_PICK: begin
          rvld_q <= 1'b0;
          if (!pick_v_q) begin
            res_q <= mk_rsp(ST_NOFIT, '0, '0);
            st_q  <= S_RESP;
          end else if (left > SW'(split_thr_i)) begin
            if (count_q >= CW'(MaxPartitions)) begin
              res_q <= mk_rsp(ST_FULL, '0, '0);
              st_q  <= S_RESP;
            end else begin
              i_q  <= count_q - 1'b1;
              st_q <= S_SHIFT;
            end
          end else st_q <= S_GRANT;
        end
        S_SHIFT: begin
          // read entry i, write it to i+1 in the next cycle, top down
          if (i_q > CW'(pick_q)) begin
            rvld_q <= 1'b1;
            ri_q   <= i_q[IW-1:0];
            i_q    <= i_q - 1'b1;
          end else begin
            rvld_q <= 1'b0;
            if (!rvld_q) st_q <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          count_q      <= count_q + 1'b1;
          pick_e_q.len <= LW'(req_q.size);
          st_q         <= S_GRANT;
        end
        S_GRANT: begin
          res_q <= mk_rsp(ST_OK, 10'(pick_e_q.start), 11'(pick_e_q.len));
          st_q  <= S_RESP;
        end
        S_FREE: begin
          // release and merge in one pass, acc_q holds the last kept entry
          if (issue) begin
            rvld_q <= 1'b1;
            ri_q   <= i_q[IW-1:0];
            i_q    <= i_q + 1'b1;
          end else rvld_q <= 1'b0;
          if (rvld_q) begin
            if (hit) found_q <= 1'b1;
            if (merge) acc_q.len <= acc_q.len + free_e.len;
            else begin
              acc_q <= free_e;
              w_q   <= w_q + 1'b1;
            end
          end else if (!issue) begin
            count_q <= found_q ? w_q : count_q;
            res_q   <= mk_rsp(found_q ? ST_OK : ST_NOTASK, '0, '0);
            st_q    <= S_RESP;
          end
        end
        S_RESP: if (!rv_q || r_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // response register holds the word while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      rsp_q <= '0;
    end else if (st_q == S_RESP && (!rv_q || r_ready_i)) begin
      rv_q  <= 1'b1;
      rsp_q <= res_q;
    end else if (r_ready_i) begin
      rv_q <= 1'b0;
    end
  end

endmodule

/* rtl/partition_allocator_first_best_fit.sv */
// top level of the partition allocator: config registers, front and back end
// depends on pafb_pkg, pafb_front, pafb_back
//
// requests arrive on the s_axis group; tdata holds opcode, task_id and
// request_size. each request gives exactly one response word on m_axis with
// status, start_addr and granted_size. the table sits in a memory read one
// entry a cycle, and a split moves the entries above the picked one up
// one place. requests run one at a time in the table sequencer, which sets
// the throughput; a two-word queue lets requests be taken while it is busy.
// a registered response holds while the receiver stalls, and the sequencer
// waits with its next response until that word is taken. reset leaves one
// free partition spanning the whole memory, written in the first cycle
// after reset, fit_mode first fit and split_threshold 5. the user must
// write configuration over cfg_we_i / cfg_idx_i / cfg_data_i only while
// the block is idle; the block itself does not enforce this.
module partition_allocator_first_best_fit
  import pafb_pkg::*;
#(
  parameter int unsigned MemoryUnits   = 1024,
  parameter int unsigned MaxPartitions = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // opcode, task_id, request_size
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, start_addr, granted_size
);

  logic        fit_mode_q;
  logic [10:0] split_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= 1'b0;
      split_thr_q <= 11'd5;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == 1'(CfgFitMode)) fit_mode_q <= cfg_data_i[0];
      else split_thr_q <= cfg_data_i;
    end
  end

  logic q_valid, q_ready;
  req_t q_req;
  rsp_t rsp;

  pafb_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata[27:0]),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_req_o   (q_req)
  );

  pafb_back #(.MemoryUnits(MemoryUnits), .MaxPartitions(MaxPartitions)) u_back (
    .clk_i, .rst_ni,
    .fit_mode_i  (fit_mode_q),
    .split_thr_i (split_thr_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .r_valid_o   (m_axis_tvalid),
    .r_ready_i   (m_axis_tready),
    .r_rsp_o     (rsp)
  );

  assign m_axis_tdata = {rsp.granted_size, rsp.start_addr, rsp.status};

endmodule

/* dv/partition_allocator_first_best_fit_tb.sv */
// testbench for the partition allocator: self-checking stream test with
// a table predictor for first fit, best fit, splitting and freeing with merge
// depends on pafb_pkg and partition_allocator_first_best_fit
`timescale 1ns / 100ps

module partition_allocator_first_best_fit_tb
  import pafb_pkg::*;
();

  localparam int unsigned MemUnits = 1024;
  localparam int unsigned MaxParts = 64;
  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic        op;
    logic [15:0] task_id;
    logic [10:0] size;
  } alloc_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [10:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // opcode, task_id, request_size
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // status, start_addr, granted_size

  partition_allocator_first_best_fit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [9:0]  tbl_start [MaxParts];
  logic [10:0] tbl_len   [MaxParts];
  logic        tbl_busy  [MaxParts];
  logic [15:0] tbl_owner [MaxParts];
  int unsigned tbl_count;
  logic        mode_best;
  logic [10:0] split_thr;

  alloc_req_t  pending_reqs [$];
  rsp_t        expected_rsps [$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned errors, stall_cycles;
  int unsigned task_pool [8];

  function automatic rsp_t predict_alloc(input logic [15:0] tid, input logic [10:0] size);
    rsp_t r;
    int pick;
    int unsigned left;
    r = '0;
    pick = -1;
    if (size == 0) begin
      r.status = ST_BADSIZE;
      return r;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (!tbl_busy[i] && tbl_len[i] >= size) begin
        if (pick < 0 || (mode_best && tbl_len[i] < tbl_len[pick])) pick = i;
        if (!mode_best) break;
      end
    end
    if (pick < 0) begin
      r.status = ST_NOFIT;
      return r;
    end
    left = tbl_len[pick] - size;
    if (left > split_thr) begin
      if (tbl_count >= MaxParts) begin
        r.status = ST_FULL;
        return r;
      end
      for (int j = tbl_count; j > pick + 1; j--) begin
        tbl_start[j] = tbl_start[j-1];
        tbl_len[j]   = tbl_len[j-1];
        tbl_busy[j]  = tbl_busy[j-1];
        tbl_owner[j] = tbl_owner[j-1];
      end
      tbl_start[pick+1] = tbl_start[pick] + size;
      tbl_len[pick+1]   = left;
      tbl_busy[pick+1]  = 1'b0;
      tbl_owner[pick+1] = '0;
      tbl_count++;
      tbl_len[pick] = size;
    end
    tbl_busy[pick]  = 1'b1;
    tbl_owner[pick] = tid;
    r.status = ST_OK;
    r.start_addr = tbl_start[pick];
    r.granted_size = tbl_len[pick];
    return r;
  endfunction

  function automatic rsp_t predict_free(input logic [15:0] tid);
    rsp_t r;
    bit found;
    int unsigned w;
    r = '0;
    found = 0;
    w = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i] && tbl_owner[i] == tid) begin
        tbl_busy[i] = 1'b0;
        tbl_owner[i] = '0;
        found = 1;
      end
    end
    if (!found) begin
      r.status = ST_NOTASK;
      return r;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (w > 0 && !tbl_busy[i] && !tbl_busy[w-1]) begin
        tbl_len[w-1] += tbl_len[i];
      end else begin
        tbl_start[w] = tbl_start[i];
        tbl_len[w]   = tbl_len[i];
        tbl_busy[w]  = tbl_busy[i];
        tbl_owner[w] = tbl_owner[i];
        w++;
      end
    end
    tbl_count = w;
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    alloc_req_t req;
    if (s_axis_tvalid && s_axis_tready) begin
      req = pending_reqs.pop_front();
      if (req.op == OP_FREE) expected_rsps.push_back(predict_free(req.task_id));
      else expected_rsps.push_back(predict_alloc(req.task_id, req.size));
    end
    if ((!s_axis_tvalid || s_axis_tready) && rst_ni) begin
      if (pending_reqs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        req = pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, req.size, req.task_id, req.op};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (m_axis_tvalid && m_axis_tready) begin
      got.status       = m_axis_tdata[2:0];
      got.start_addr   = m_axis_tdata[12:3];
      got.granted_size = m_axis_tdata[23:13];
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = expected_rsps.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.start_addr != want.start_addr)
          report_mismatch("start_addr", got.start_addr, want.start_addr);
        if (got.granted_size != want.granted_size)
          report_mismatch("granted_size", got.granted_size, want.granted_size);
      end
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_req(input logic op, input logic [15:0] tid, input logic [10:0] size);
    alloc_req_t r;
    r.op = op;
    r.task_id = tid;
    r.size = size;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [10:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == 1'(CfgFitMode)) mode_best = val[0];
    else split_thr = val;
  endtask

  // mostly allocations from a small task pool, frees to keep memory cycling
  task automatic random_batch(input int unsigned n);
    int unsigned k;
    logic [10:0] sz;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) begin
        sz = ($urandom_range(9) == 0) ? 11'($urandom_range(2047))
                                      : 11'($urandom_range(1, 64));
        add_req(OP_ALLOC, 16'(task_pool[$urandom_range(7)]), sz);
      end else if (k < 90) begin
        add_req(OP_FREE, 16'(task_pool[$urandom_range(7)]), 11'($urandom));
      end else begin
        add_req(k[0] ? OP_FREE : OP_ALLOC, 16'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MaxParts; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_busy[i] = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_len[0] = 11'(MemUnits);
    tbl_count = 1;
    mode_best = 1'b0;
    split_thr = 11'd5;
    errors = 0;
    stall_cycles = 0;
    send_idle_pct = 7;
    recv_idle_pct = 74;
    task_pool = '{0, 1, 2, 3, 16'hffff, 16'h5aa5, 16'ha55a, 7};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero size, oversize, unknown task, exact fit, splits, reuse of a freed entry
    add_req(OP_ALLOC, 16'h0000, 11'd0);
    add_req(OP_ALLOC, 16'hffff, 11'd2047);
    add_req(OP_ALLOC, 16'h0001, 11'd1025);
    add_req(OP_FREE, 16'h1234, 11'd2047);
    add_req(OP_ALLOC, 16'hffff, 11'd1024);
    add_req(OP_FREE, 16'hffff, 11'd0);
    add_req(OP_ALLOC, 16'h0001, 11'd1020);
    add_req(OP_FREE, 16'h0001, 11'd0);
    for (int i = 0; i < 14; i++) add_req(OP_ALLOC, 16'(i), 11'd1);
    add_req(OP_FREE, 16'd3, 11'd0);
    add_req(OP_ALLOC, 16'haaaa, 11'd1);
    drain();
    // fill the table until it reports full, then clean up
    for (int i = 0; i < 66; i++) add_req(OP_ALLOC, 16'h5555, 11'd2);
    add_req(OP_FREE, 16'h5555, 11'd0);
    for (int i = 0; i < 15; i++) add_req(OP_FREE, 16'(i), 11'd0);
    add_req(OP_FREE, 16'haaaa, 11'd0);
    drain();

    write_cfg(1'(CfgFitMode), 11'd1);
    write_cfg(1'(CfgSplitThr), 11'd0);
    random_batch(250);
    drain();
    send_idle_pct = 74;
    recv_idle_pct = 7;
    write_cfg(1'(CfgSplitThr), 11'd1024);
    random_batch(150);
    drain();
    write_cfg(1'(CfgFitMode), 11'd0);
    write_cfg(1'(CfgSplitThr), 11'd0);
    random_batch(150);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(1'(CfgSplitThr), 11'd17);
    random_batch(200);
    drain();
    write_cfg(1'(CfgFitMode), 11'd1);
    write_cfg(1'(CfgSplitThr), 11'd5);
    random_batch(200);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
